@@ design/gds_pkg.sv @@
// ----------------------------------------------------------------------------
// gds_pkg: shared types and calendar helpers
// Action codes, controller states, command/status bundles and the month and
// leap-year functions used by the date stepper.
// ----------------------------------------------------------------------------
package gds_pkg;

  localparam int unsigned YearW  = 14;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW   = 5;
  localparam int unsigned DeltaW = 13;
  localparam int unsigned StepW  = 12;
  localparam int unsigned WdayW  = 3;

  localparam int unsigned SDataW = 40;
  localparam int unsigned SUserW = 2;
  localparam int unsigned MDataW = 32;

  localparam logic [YearW-1:0] YearMin  = YearW'(1);
  localparam logic [YearW-1:0] YearMax  = YearW'(9999);
  localparam logic [StepW-1:0] MaxSteps = StepW'(4095);

  typedef enum logic [1:0] {
    ACT_LOAD = 2'd0,
    ACT_ADD  = 2'd1,
    ACT_CMP  = 2'd2,
    ACT_NONE = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_STEP,
    ST_WD0,
    ST_WD1,
    ST_WD2,
    ST_WD3,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic latch;
    logic exec;
    logic step;
    logic wd0;
    logic wd1;
    logic wd2;
    logic wd3;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic add_action;
    logic steps_zero;
  } stat_t;

  // Divisible by 25 via multiply by the inverse of 25 mod 2^14.
  function automatic logic is_leap(input logic [YearW-1:0] y);
    logic [2*YearW-1:0] prod;
    logic               div25;
    prod  = (2*YearW)'(y) * (2*YearW)'(7209);
    div25 = (prod[YearW-1:0] <= YearW'(655));
    return ((y[1:0] == 2'b00) && !div25) || ((y[3:0] == 4'b0000) && div25);
  endfunction

  function automatic logic [DayW-1:0] days_in(input logic leap,
                                               input logic [MonthW-1:0] m);
    logic [DayW-1:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DayW'(31);
      4'd4, 4'd6, 4'd9, 4'd11:                    len = DayW'(30);
      4'd2:                                       len = leap ? DayW'(29) : DayW'(28);
      default:                                    len = '0;
    endcase
    return len;
  endfunction

  // floor(3*(m+1)/5) for the shifted month 3..14
  function automatic logic [3:0] month_term(input logic [MonthW-1:0] m);
    logic [3:0] t;
    case (m)
      4'd3:    t = 4'd2;
      4'd4:    t = 4'd3;
      4'd5:    t = 4'd3;
      4'd6:    t = 4'd4;
      4'd7:    t = 4'd4;
      4'd8:    t = 4'd5;
      4'd9:    t = 4'd6;
      4'd10:   t = 4'd6;
      4'd11:   t = 4'd7;
      4'd12:   t = 4'd7;
      4'd13:   t = 4'd8;
      4'd14:   t = 4'd9;
      default: t = 4'd0;
    endcase
    return t;
  endfunction

endpackage

@@ design/gds_ctrl.sv @@
// ----------------------------------------------------------------------------
// gds_ctrl: sequencer of the date stepper
// Takes a request, runs the action, the day steps and the weekday pipeline,
// then hands the result to the output register.
// ----------------------------------------------------------------------------
module gds_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_axis_tvalid,
  output logic           s_axis_tready,
  output logic           m_axis_tvalid,
  input  logic           m_axis_tready,
  input  gds_pkg::stat_t stat_i,
  output gds_pkg::cmd_t  cmd_o
);
  import gds_pkg::*;

  state_e state_q, state_d;
  logic   m_valid_q, m_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    s_axis_tready = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd_o.latch = 1'b1;
          state_d     = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = stat_i.add_action ? ST_STEP : ST_WD0;
      end
      ST_STEP: begin
        if (stat_i.steps_zero) begin
          state_d = ST_WD0;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      ST_WD0: begin
        cmd_o.wd0 = 1'b1;
        state_d   = ST_WD1;
      end
      ST_WD1: begin
        cmd_o.wd1 = 1'b1;
        state_d   = ST_WD2;
      end
      ST_WD2: begin
        cmd_o.wd2 = 1'b1;
        state_d   = ST_WD3;
      end
      ST_WD3: begin
        cmd_o.wd3 = 1'b1;
        state_d   = ST_DONE;
      end
      ST_DONE: begin
        // hold until the output register is free or drains this cycle
        if (!m_valid_q || m_axis_tready) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    m_valid_d = m_valid_q;
    if (cmd_o.out_load) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  assign m_axis_tvalid = m_valid_q;

  a_accept_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> (state_q == ST_EXEC))
    else $error("accepted request did not start execution");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!m_valid_q || m_axis_tready))
    else $error("result register overwritten while full");

  a_step_until_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_STEP && !stat_i.steps_zero) |=> (state_q == ST_STEP))
    else $error("stepping left with steps pending");

endmodule

@@ design/gds_datapath.sv @@
// ----------------------------------------------------------------------------
// gds_datapath: date registers, day stepper and weekday pipeline
// Holds the stored date, applies load/compare/step commands and computes the
// weekday over four registered stages.
// ----------------------------------------------------------------------------
module gds_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  gds_pkg::cmd_t               cmd_i,
  output gds_pkg::stat_t              stat_o,
  input  logic [gds_pkg::SUserW-1:0]  s_axis_tuser,
  input  logic [gds_pkg::SDataW-1:0]  s_axis_tdata,
  output logic [gds_pkg::MDataW-1:0]  m_axis_tdata
);
  import gds_pkg::*;

  // latched request
  action_e           act_q;
  logic [DeltaW-1:0] delta_q;
  logic [YearW-1:0]  iy_q;
  logic [MonthW-1:0] im_q;
  logic [DayW-1:0]   id_q;

  // stored date and step count
  logic [YearW-1:0]  cur_year_q, cur_year_d;
  logic [MonthW-1:0] cur_month_q, cur_month_d;
  logic [DayW-1:0]   cur_day_q, cur_day_d;
  logic [StepW-1:0]  steps_q, steps_d;
  logic              eq_q, eq_d;
  logic              err_q, err_d;

  // weekday pipeline
  logic [YearW-1:0]  wy_q, wy_d;
  logic [MonthW-1:0] wm_q, wm_d;
  logic [DayW-1:0]   wd_q;
  logic [25:0]       wp_q;
  logic [YearW-1:0]  ws_q;
  logic [27:0]       wprod_q;
  logic [WdayW-1:0]  weekday_q;
  logic [MDataW-1:0] out_q;

  logic              back;
  logic [DeltaW-1:0] mag;
  logic [StepW-1:0]  mag_cap;
  logic [DayW-1:0]   cur_len;
  logic              load_ok;
  logic              blocked;
  logic [6:0]        cent;
  logic [14:0]       ssum;
  logic [10:0]       quot;
  logic [YearW-1:0]  rem;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      act_q   <= action_e'(s_axis_tuser[1:0]);
      delta_q <= s_axis_tdata[12:0];
      iy_q    <= s_axis_tdata[26:13];
      im_q    <= s_axis_tdata[30:27];
      id_q    <= s_axis_tdata[35:31];
    end
  end

  assign back    = delta_q[DeltaW-1];
  assign mag     = back ? (~delta_q + DeltaW'(1)) : delta_q;
  assign mag_cap = (mag > DeltaW'(MaxSteps)) ? MaxSteps : mag[StepW-1:0];
  assign cur_len = days_in(is_leap(cur_year_q), cur_month_q);
  assign load_ok = (iy_q >= YearMin) && (iy_q <= YearMax) && (id_q != '0) &&
                   (id_q <= days_in(is_leap(iy_q), im_q));
  assign blocked = back ?
      ((cur_day_q <= DayW'(1)) && (cur_month_q <= MonthW'(1)) && (cur_year_q <= YearMin)) :
      ((cur_day_q >= cur_len) && (cur_month_q >= MonthW'(12)) && (cur_year_q >= YearMax));

  always_comb begin
    cur_year_d  = cur_year_q;
    cur_month_d = cur_month_q;
    cur_day_d   = cur_day_q;
    steps_d     = steps_q;
    eq_d        = eq_q;
    err_d       = err_q;
    if (cmd_i.exec) begin
      eq_d  = 1'b0;
      err_d = 1'b0;
      case (act_q)
        ACT_LOAD: begin
          if (load_ok) begin
            cur_year_d  = iy_q;
            cur_month_d = im_q;
            cur_day_d   = id_q;
          end else begin
            err_d = 1'b1;
          end
        end
        ACT_ADD: begin
          steps_d = mag_cap;
        end
        ACT_CMP: begin
          eq_d = (iy_q == cur_year_q) && (im_q == cur_month_q) && (id_q == cur_day_q);
        end
        default: begin
          eq_d = 1'b0;
        end
      endcase
    end else if (cmd_i.step) begin
      if (blocked) begin
        // drop the remaining steps at the range limit
        err_d   = 1'b1;
        steps_d = '0;
      end else begin
        steps_d = steps_q - StepW'(1);
        if (!back) begin
          if (cur_day_q < cur_len) begin
            cur_day_d = cur_day_q + DayW'(1);
          end else if (cur_month_q < MonthW'(12)) begin
            cur_month_d = cur_month_q + MonthW'(1);
            cur_day_d   = DayW'(1);
          end else begin
            cur_year_d  = cur_year_q + YearW'(1);
            cur_month_d = MonthW'(1);
            cur_day_d   = DayW'(1);
          end
        end else begin
          if (cur_day_q > DayW'(1)) begin
            cur_day_d = cur_day_q - DayW'(1);
          end else if (cur_month_q > MonthW'(1)) begin
            cur_month_d = cur_month_q - MonthW'(1);
            cur_day_d   = days_in(is_leap(cur_year_q), cur_month_q - MonthW'(1));
          end else begin
            cur_year_d  = cur_year_q - YearW'(1);
            cur_month_d = MonthW'(12);
            cur_day_d   = DayW'(31);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_year_q  <= YearW'(1);
      cur_month_q <= MonthW'(1);
      cur_day_q   <= DayW'(1);
      steps_q     <= '0;
      eq_q        <= 1'b0;
      err_q       <= 1'b0;
    end else begin
      cur_year_q  <= cur_year_d;
      cur_month_q <= cur_month_d;
      cur_day_q   <= cur_day_d;
      steps_q     <= steps_d;
      eq_q        <= eq_d;
      err_q       <= err_d;
    end
  end

  // January and February count as months 13 and 14 of the previous year
  always_comb begin
    if (cur_month_q <= MonthW'(2)) begin
      wm_d = cur_month_q + MonthW'(12);
      wy_d = cur_year_q - YearW'(1);
    end else begin
      wm_d = cur_month_q;
      wy_d = cur_year_q;
    end
  end

  // year/100 by reciprocal, sum mod 7 by reciprocal and correction
  assign cent = wp_q[25:19];
  assign ssum = 15'(wd_q) + 15'({wm_q, 1'b0}) + 15'(month_term(wm_q)) + 15'(wy_q) +
                15'(wy_q[YearW-1:2]) - 15'(cent) + 15'(cent[6:2]);
  assign quot = wprod_q[27:17];
  assign rem  = ws_q - YearW'(YearW'(quot) * YearW'(7));

  always_ff @(posedge clk_i) begin
    if (cmd_i.wd0) begin
      wy_q <= wy_d;
      wm_q <= wm_d;
      wd_q <= cur_day_q;
      wp_q <= 26'(26'(wy_d) * 26'd5243);
    end
    if (cmd_i.wd1) begin
      ws_q <= ssum[YearW-1:0];
    end
    if (cmd_i.wd2) begin
      wprod_q <= 28'(28'(ws_q) * 28'd18725);
    end
    if (cmd_i.wd3) begin
      weekday_q <= rem[WdayW-1:0];
    end
    if (cmd_i.out_load) begin
      out_q <= {4'b0000, err_q, eq_q, weekday_q, cur_day_q, cur_month_q, cur_year_q};
    end
  end

  assign stat_o.add_action   = (act_q == ACT_ADD);
  assign stat_o.steps_zero   = (steps_q == '0);
  assign m_axis_tdata        = out_q;

  a_block_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.step && blocked) |=> ((steps_q == '0) && err_q))
    else $error("range limit did not drop the remaining steps");

  a_weekday_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wd3 |=> (weekday_q <= WdayW'(6)))
    else $error("weekday reduction out of range");

  a_month_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_month_q >= MonthW'(1)) && (cur_month_q <= MonthW'(12)))
    else $error("stored month out of range");

endmodule

@@ design/gregorian_date_stepper.sv @@
// ----------------------------------------------------------------------------
// gregorian_date_stepper: Gregorian date register with day stepping
// Loads, steps or compares a stored date and reports it with its weekday.
// ----------------------------------------------------------------------------
// Usage:
//   Each request on the slave stream carries an action in tuser (load, add
//   signed day count, compare, none) and the operands in tdata. Exactly one
//   result leaves on the master stream: the stored date after the action,
//   its weekday (0 Monday), the compare flag and the range error flag.
//   Load, compare and none run the action and then the weekday reduction;
//   an add of N days steps the date in between, since the day stepper
//   advances the date by one day per cycle (N capped at 4095; a range
//   limit ends the stepping early). The weekday comes from a four-stage
//   reduction after the action, and the finished result is then written
//   into the output register before it leaves on the master stream.
//   One request is in flight at a time; the next is taken as soon as the
//   result sits in the output register, even if the receiver stalls it.
//   A stalled result holds its data; a second finished result waits inside
//   the block until the output register drains.
//   Reset sets the date to 0001-01-01 (Monday) and empties the output.
// ----------------------------------------------------------------------------
module gregorian_date_stepper (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // [1:0] action
  input  logic [gds_pkg::SUserW-1:0]  s_axis_tuser,
  // [12:0] day_delta, [26:13] in_year, [30:27] in_month, [35:31] in_day
  input  logic [gds_pkg::SDataW-1:0]  s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // [13:0] out_year, [17:14] out_month, [22:18] out_day, [25:23] weekday,
  // [26] dates_equal, [27] range_error
  output logic [gds_pkg::MDataW-1:0]  m_axis_tdata
);
  import gds_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  gds_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .stat_i        (stat),
    .cmd_o         (cmd)
  );

  gds_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tdata (m_axis_tdata)
  );

endmodule

@@ dv/gds_checker.sv @@
// ----------------------------------------------------------------------------
// gds_checker: result predictor and scoreboard for the date stepper
// Watches both streams, keeps its own copy of the stored date, works out the
// result of every accepted request and compares each result, field by field,
// against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module gds_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  input  logic                        s_axis_tready,
  // [1:0] action
  input  logic [gds_pkg::SUserW-1:0]  s_axis_tuser,
  // [12:0] day_delta, [26:13] in_year, [30:27] in_month, [35:31] in_day
  input  logic [gds_pkg::SDataW-1:0]  s_axis_tdata,
  input  logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // [13:0] out_year, [17:14] out_month, [22:18] out_day, [25:23] weekday,
  // [26] dates_equal, [27] range_error
  input  logic [gds_pkg::MDataW-1:0]  m_axis_tdata,
  output int unsigned                 fail_count_o,
  output int unsigned                 pending_o
);
  import gds_pkg::*;

  // Laid out MSB first so that it maps straight onto m_axis_tdata[27:0].
  typedef struct packed {
    logic              range_err;
    logic              same;
    logic [WdayW-1:0]  wday;
    logic [DayW-1:0]   day;
    logic [MonthW-1:0] month;
    logic [YearW-1:0]  year;
  } date_result_t;

  date_result_t pending_dates[$];
  int unsigned  fail_count = 0;
  int unsigned  date_year  = 1;
  int unsigned  date_month = 1;
  int unsigned  date_day   = 1;

  assign fail_count_o = fail_count;
  assign pending_o    = pending_dates.size();

  task automatic report(input string msg);
    $display("%0t: %s", $time, msg);
    fail_count++;
  endtask

  function automatic bit leap_year(input int unsigned y);
    return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
  endfunction

  function automatic int unsigned month_length(input int unsigned y, input int unsigned m);
    case (m)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      2:                     return leap_year(y) ? 29 : 28;
      default:               return 0;
    endcase
  endfunction

  // Zeller-style sum with January and February counted as months 13 and 14
  // of the year before; 0 is Monday.
  function automatic int unsigned weekday_of_date(input int unsigned y, input int unsigned m,
                                                  input int unsigned d);
    int unsigned yy;
    int unsigned mm;
    yy = y;
    mm = m;
    if (mm <= 2) begin
      mm += 12;
      yy -= 1;
    end
    return (d + 2 * mm + (3 * (mm + 1)) / 5 + yy + yy / 4 - yy / 100 + yy / 400) % 7;
  endfunction

  function bit advance_day();
    if (date_day < month_length(date_year, date_month)) begin
      date_day++;
      return 1'b1;
    end
    if (date_month < 12) begin
      date_month++;
      date_day = 1;
      return 1'b1;
    end
    if (date_year >= YearMax) return 1'b0;
    date_year++;
    date_month = 1;
    date_day   = 1;
    return 1'b1;
  endfunction

  // Month length comes from the month stepped into.
  function bit retreat_day();
    if (date_day > 1) begin
      date_day--;
      return 1'b1;
    end
    if (date_month > 1) begin
      date_month--;
    end else begin
      if (date_year <= YearMin) return 1'b0;
      date_year--;
      date_month = 12;
    end
    date_day = month_length(date_year, date_month);
    return 1'b1;
  endfunction

  function date_result_t predict_date(input logic [SUserW-1:0] act,
                                      input logic [SDataW-1:0] data);
    logic signed [DeltaW-1:0] delta;
    int unsigned              y;
    int unsigned              m;
    int unsigned              d;
    int unsigned              steps;
    bit                       back;
    date_result_t             r;
    delta = data[12:0];
    y     = data[26:13];
    m     = data[30:27];
    d     = data[35:31];
    r     = '0;
    case (action_e'(act))
      ACT_LOAD: begin
        if (y >= YearMin && y <= YearMax && d >= 1 && d <= month_length(y, m)) begin
          date_year  = y;
          date_month = m;
          date_day   = d;
        end else begin
          r.range_err = 1'b1;
        end
      end
      ACT_ADD: begin
        back  = delta < 0;
        steps = back ? -int'(delta) : int'(delta);
        if (steps > MaxSteps) steps = MaxSteps;
        // drop the remaining steps once a range limit blocks one
        while (steps > 0 && !r.range_err) begin
          r.range_err = back ? !retreat_day() : !advance_day();
          steps--;
        end
      end
      ACT_CMP: begin
        r.same = (y == date_year) && (m == date_month) && (d == date_day);
      end
      default: ;
    endcase
    r.year  = YearW'(date_year);
    r.month = MonthW'(date_month);
    r.day   = DayW'(date_day);
    r.wday  = WdayW'(weekday_of_date(date_year, date_month, date_day));
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    date_result_t got;
    date_result_t want;
    if (!rst_ni) begin
      date_year  = 1;
      date_month = 1;
      date_day   = 1;
      pending_dates.delete();
    end else begin
      // results leave before the next request can finish, so pop first
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[27:0];
        if (pending_dates.size() == 0) begin
          report($sformatf("result %0d-%0d-%0d with no request waiting",
                           got.year, got.month, got.day));
        end else begin
          want = pending_dates.pop_front();
          if (got.year != want.year)
            report($sformatf("out_year got %0d expected %0d", got.year, want.year));
          if (got.month != want.month)
            report($sformatf("out_month got %0d expected %0d", got.month, want.month));
          if (got.day != want.day)
            report($sformatf("out_day got %0d expected %0d", got.day, want.day));
          if (got.wday != want.wday)
            report($sformatf("weekday got %0d expected %0d", got.wday, want.wday));
          if (got.same != want.same)
            report($sformatf("dates_equal got %0d expected %0d", got.same, want.same));
          if (got.range_err != want.range_err)
            report($sformatf("range_error got %0d expected %0d",
                             got.range_err, want.range_err));
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        pending_dates.push_back(predict_date(s_axis_tuser, s_axis_tdata));
    end
  end

endmodule

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: testbench for the Gregorian date stepper
// Drives directed date requests (range limits, leap years, invalid loads,
// capped deltas) and then random load/step/compare runs with bursty requests
// and a stalling receiver; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;
  import gds_pkg::*;

  localparam int unsigned QuietLimit = 30000;
  localparam int unsigned RandomReqs = 110;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [SUserW-1:0]   s_axis_tuser  = '0;
  logic [SDataW-1:0]   s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [MDataW-1:0]   m_axis_tdata;
  int unsigned         fail_count;
  int unsigned         pending;
  int unsigned         quiet_cycles  = 0;
  int unsigned         burst_left    = 0;
  int unsigned         random_sent   = 0;
  logic [15:0]         ready_pat     = 16'hFFFF;
  logic [5:0]          ready_cnt     = '0;

  always #5 clk_i = ~clk_i;

  gregorian_date_stepper dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  gds_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  // Receiver: rotate a 16-bit ready pattern, reroll it whenever the 6-bit counter wraps.
  always @(posedge clk_i) begin
    ready_cnt <= ready_cnt + 1'b1;
    if (ready_cnt == '0) begin
      case ($urandom_range(0, 3))
        0:       ready_pat <= 16'hFFFF;
        1:       ready_pat <= 16'($urandom());
        2:       ready_pat <= 16'($urandom()) & 16'($urandom());
        default: ready_pat <= 16'($urandom()) | 16'h0101;
      endcase
    end else begin
      ready_pat <= {ready_pat[0], ready_pat[15:1]};
    end
    m_axis_tready <= ready_pat[0];
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QuietLimit);
    $display("gregorian_date_stepper test failed");
    $finish;
  end

  // One request; opens a new burst after a random gap when the last one ran out.
  task automatic send_req(input action_e act, input logic [DeltaW-1:0] delta,
                          input logic [YearW-1:0] year, input logic [MonthW-1:0] month,
                          input logic [DayW-1:0] day);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? 30 : $urandom_range(1, 8);
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {4'b0, day, month, year, delta};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic pick_date(output int unsigned y, output int unsigned m,
                           output int unsigned d);
    case ($urandom_range(0, 5))
      0:       y = $urandom_range(1, 3);
      1:       y = $urandom_range(9997, 9999);
      2:       y = 100 * $urandom_range(1, 99);
      default: y = $urandom_range(1, 9999);
    endcase
    m = $urandom_range(1, 12);
    // month ends sometimes overshoot and give a refused load
    d = ($urandom_range(0, 3) == 0) ? $urandom_range(28, 31) : $urandom_range(1, 28);
  endtask

  function automatic int pick_delta();
    int k;
    if ($urandom_range(0, 19) == 0) begin
      if ($urandom_range(0, 5) == 0) return -4096;
      k = $urandom_range(1000, 4095);
    end else begin
      k = $urandom_range(0, 60);
    end
    return $urandom_range(0, 1) ? -k : k;
  endfunction

  task automatic send_random(input action_e act, input int delta, input int unsigned y,
                             input int unsigned m, input int unsigned d);
    send_req(act, DeltaW'(delta), YearW'(y), MonthW'(m), DayW'(d));
    random_sent++;
  endtask

  initial begin
    int unsigned y;
    int unsigned m;
    int unsigned d;
    int          k;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset date, invalid loads and the lower limit.
    send_req(ACT_NONE, 13'h1FFF, 14'h3FFF, 4'hF, 5'h1F);
    send_req(ACT_CMP,  13'h0000, 14'd1, 4'd1, 5'd1);
    send_req(ACT_ADD,  13'h1FFF, 14'd0, 4'd0, 5'd0);
    send_req(ACT_LOAD, 13'h0000, 14'd0, 4'd1, 5'd1);
    send_req(ACT_LOAD, 13'h0000, 14'd10000, 4'd1, 5'd1);
    send_req(ACT_LOAD, 13'h1FFF, 14'h3FFF, 4'hF, 5'h1F);
    send_req(ACT_LOAD, 13'h0000, 14'd2023, 4'd2, 5'd29);
    send_req(ACT_LOAD, 13'h0000, 14'd2023, 4'd0, 5'd1);
    send_req(ACT_LOAD, 13'h0000, 14'd2023, 4'd4, 5'd0);
    // Leap rules: century years are leap only on multiples of 400.
    send_req(ACT_LOAD, 13'h0000, 14'd2024, 4'd2, 5'd29);
    send_req(ACT_ADD,  13'd1,    14'd0, 4'd0, 5'd0);
    send_req(ACT_ADD,  -13'sd1,  14'd0, 4'd0, 5'd0);
    send_req(ACT_LOAD, 13'h0000, 14'd1900, 4'd2, 5'd28);
    send_req(ACT_ADD,  13'd1,    14'd0, 4'd0, 5'd0);
    send_req(ACT_LOAD, 13'h0000, 14'd2000, 4'd2, 5'd28);
    send_req(ACT_ADD,  13'd1,    14'd0, 4'd0, 5'd0);
    // Step back across a month end picks up the new month's length.
    send_req(ACT_LOAD, 13'h0000, 14'd2001, 4'd3, 5'd1);
    send_req(ACT_ADD,  -13'sd1,  14'd0, 4'd0, 5'd0);
    send_req(ACT_ADD,  13'd0,    14'd0, 4'd0, 5'd0);
    // Upper limit, compare with a bad date, capped deltas.
    send_req(ACT_LOAD, 13'h0000, 14'd9999, 4'd12, 5'd31);
    send_req(ACT_ADD,  13'd1,    14'd0, 4'd0, 5'd0);
    send_req(ACT_CMP,  13'h0000, 14'd9999, 4'd13, 5'd31);
    send_req(ACT_ADD,  13'h1000, 14'd0, 4'd0, 5'd0);
    send_req(ACT_ADD,  13'd4095, 14'd0, 4'd0, 5'd0);
    send_req(ACT_LOAD, 13'h0000, 14'd1, 4'd3, 5'd1);
    send_req(ACT_ADD,  13'h1000, 14'd0, 4'd0, 5'd0);

    drain_results();

    while (random_sent < RandomReqs) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          pick_date(y, m, d);
          send_random(ACT_LOAD, int'($urandom_range(0, 8191)), y, m, d);
          repeat ($urandom_range(1, 4)) begin
            k = pick_delta();
            case ($urandom_range(0, 3))
              0: begin
                // out and back should land on the loaded date again
                send_random(ACT_ADD, k, $urandom_range(0, 16383), 0, 0);
                send_random(ACT_ADD, -k, 0, $urandom_range(0, 15), 0);
                send_random(ACT_CMP, 0, y, m, d);
              end
              1:       send_random(ACT_CMP, k, y, m, d);
              default: send_random(ACT_ADD, k, 0, 0, $urandom_range(0, 31));
            endcase
          end
        end
        6, 7: begin
          send_random(action_e'($urandom_range(0, 3)), $urandom_range(0, 200) - 100,
                      $urandom_range(0, 16383), $urandom_range(0, 15),
                      $urandom_range(0, 31));
        end
        8: begin
          send_random(action_e'($urandom_range(ACT_CMP, ACT_NONE)),
                      int'($urandom_range(0, 8191)), $urandom_range(0, 16383),
                      $urandom_range(0, 15), $urandom_range(0, 31));
        end
        default: begin
          // run into a range limit from close by
          if ($urandom_range(0, 1)) begin
            send_random(ACT_LOAD, 0, 9999, 12, $urandom_range(1, 31));
            send_random(ACT_ADD, $urandom_range(1, 60), 0, 0, 0);
          end else begin
            send_random(ACT_LOAD, 0, 1, 1, $urandom_range(1, 31));
            send_random(ACT_ADD, -int'($urandom_range(1, 60)), 0, 0, 0);
          end
        end
      endcase
    end

    drain_results();
    repeat (40) @(posedge clk_i);
    if (fail_count == 0)
      $display("gregorian_date_stepper test passed");
    else
      $display("gregorian_date_stepper test failed");
    $finish;
  end

endmodule
